>>> rtl/cpsat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the convex polygon separating-axis test unit.
// Used by the controller, the datapath and the top level; depends on nothing.

package cpsat_pkg;

	localparam int MAX_VERTICES = 8;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int MIN_VERTICES = 3;

	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS = 16;
	localparam int IT_W = 5;

	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_EVAL = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FEW = 2'd1;
	localparam logic [1:0] STATUS_OVF = 2'd2;

	localparam logic [15:0] Q14_ONE = 16'd16384;

	localparam logic [4:0] DP_NOP = 5'd0;
	localparam logic [4:0] DP_LOAD = 5'd1;
	localparam logic [4:0] DP_START = 5'd2;
	localparam logic [4:0] DP_LATCH0 = 5'd3;
	localparam logic [4:0] DP_EDGE = 5'd4;
	localparam logic [4:0] DP_NORM = 5'd5;
	localparam logic [4:0] DP_SQ1 = 5'd6;
	localparam logic [4:0] DP_SQ2 = 5'd7;
	localparam logic [4:0] DP_SQRT = 5'd8;
	localparam logic [4:0] DP_DIVINIT_X = 5'd9;
	localparam logic [4:0] DP_DIVINIT_Y = 5'd10;
	localparam logic [4:0] DP_DIV = 5'd11;
	localparam logic [4:0] DP_QY = 5'd12;
	localparam logic [4:0] DP_PMUL = 5'd13;
	localparam logic [4:0] DP_PACC = 5'd14;
	localparam logic [4:0] DP_AXIS = 5'd15;
	localparam logic [4:0] DP_MISS = 5'd16;
	localparam logic [4:0] DP_FMUL = 5'd17;
	localparam logic [4:0] DP_FLIP = 5'd18;
	localparam logic [4:0] DP_PUSH = 5'd19;

	typedef struct packed {
		logic [4:0] op;
		logic rd;
		logic sel;
		logic [IDX_W-1:0] idx;
		logic first;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt_a;
		logic [CNT_W-1:0] cnt_b;
		logic err;
		logic zero;
		logic m_ok;
		logic gap;
	} stat_t;

endpackage

>>> rtl/cpsat_dp.sv
`timescale 1ns / 1ps
// Datapath: vertex stores, edge normal unit (normalize, square, root, divide),
// projection and axis selection, result registers. Depends on cpsat_pkg.

module cpsat_dp (
	input logic clk,
	input logic arst_n,
	input cpsat_pkg::cmd_t cmd,
	output cpsat_pkg::stat_t stat,
	input logic [31:0] vertex_x,
	input logic [31:0] vertex_y,
	input logic [31:0] center_a_x,
	input logic [31:0] center_a_y,
	input logic [31:0] center_b_x,
	input logic [31:0] center_b_y,
	output logic hit,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic [31:0] depth,
	output logic [1:0] status
);
	import cpsat_pkg::*;

	logic [63:0] mem_a [MAX_VERTICES];
	logic [63:0] mem_b [MAX_VERTICES];
	logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic ovf_q;

	logic [63:0] rd_q, e0_q;
	logic [31:0] cax_q, cay_q, cbx_q, cby_q;
	logic [32:0] ax_q, ay_q;
	logic neg_x_q, neg_y_q;
	logic [59:0] prod_q;
	logic [60:0] sq_rem_q, sq_res_q, sq_bit_q;
	logic [30:0] dr_q;
	logic [15:0] dn_q, dq_q;
	logic [15:0] qx_q;
	logic signed [15:0] nx_q, ny_q;
	logic signed [47:0] px_q, py_q;
	logic signed [48:0] min_a_q, max_a_q, min_b_q, max_b_q;
	logic signed [49:0] best_q;
	logic have_q;
	logic signed [15:0] bx_q, by_q;
	logic signed [48:0] fx_q, fy_q;
	logic res_hit_q;
	logic signed [15:0] res_nx_q, res_ny_q;
	logic [31:0] res_depth_q;
	logic [1:0] res_status_q;

	logic signed [32:0] ex, ey;
	logic [32:0] m;
	logic [30:0] len;
	logic [59:0] sq_y;
	logic [61:0] sq_t;
	logic [44:0] num_x, num_y;
	logic [31:0] dt;
	logic dq_bit;
	logic [15:0] dq_next, q_clamp;
	logic signed [48:0] p;
	logic signed [49:0] d1, d2, d;
	logic signed [32:0] dx, dy;
	logic signed [49:0] dot;
	logic [50:0] dep_r;
	logic short_cnt;

	assign ex = $signed({rd_q[31], rd_q[31:0]}) - $signed({e0_q[31], e0_q[31:0]});
	assign ey = $signed({rd_q[63], rd_q[63:32]}) - $signed({e0_q[63], e0_q[63:32]});
	assign m = (ax_q > ay_q) ? ax_q : ay_q;
	assign len = sq_res_q[30:0];
	assign sq_y = ay_q[29:0] * ay_q[29:0];
	assign sq_t = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
	assign num_x = {1'b0, ax_q[29:0], 14'd0} + {15'd0, len[30:1]};
	assign num_y = {1'b0, ay_q[29:0], 14'd0} + {15'd0, len[30:1]};
	assign dt = {dr_q, dn_q[15]};
	assign dq_bit = dt >= {1'b0, len};
	assign dq_next = {dq_q[14:0], dq_bit};
	assign q_clamp = (dq_q > Q14_ONE) ? Q14_ONE : dq_q;
	assign p = 49'(px_q) + 49'(py_q);
	assign d1 = 50'(max_b_q) - 50'(min_a_q);
	assign d2 = 50'(max_a_q) - 50'(min_b_q);
	assign d = (d1 < d2) ? d1 : d2;
	assign dx = $signed({cbx_q[31], cbx_q}) - $signed({cax_q[31], cax_q});
	assign dy = $signed({cby_q[31], cby_q}) - $signed({cay_q[31], cay_q});
	assign dot = 50'(fx_q) + 50'(fy_q);
	assign dep_r = 51'(best_q) + 51'd8192;
	assign short_cnt = (cnt_a_q < CNT_W'(MIN_VERTICES)) || (cnt_b_q < CNT_W'(MIN_VERTICES));

	assign stat.cnt_a = cnt_a_q;
	assign stat.cnt_b = cnt_b_q;
	assign stat.err = ovf_q || short_cnt;
	assign stat.zero = (ax_q == '0) && (ay_q == '0);
	assign stat.m_ok = (m[32:30] == '0) && (m[29] == 1'b1);
	assign stat.gap = (min_a_q >= max_b_q) || (min_b_q >= max_a_q);

	always_ff @(posedge clk) begin
		if (cmd.op == DP_LOAD && !cmd.sel && cnt_a_q < CNT_W'(MAX_VERTICES)) begin
			mem_a[cnt_a_q[IDX_W-1:0]] <= {vertex_y, vertex_x};
		end
		if (cmd.op == DP_LOAD && cmd.sel && cnt_b_q < CNT_W'(MAX_VERTICES)) begin
			mem_b[cnt_b_q[IDX_W-1:0]] <= {vertex_y, vertex_x};
		end
		if (cmd.rd) begin
			rd_q <= cmd.sel ? mem_b[cmd.idx] : mem_a[cmd.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.op == DP_PUSH) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.op == DP_LOAD) begin
			if (!cmd.sel) begin
				if (cnt_a_q < CNT_W'(MAX_VERTICES)) cnt_a_q <= cnt_a_q + 1'b1;
				else ovf_q <= 1'b1;
			end else begin
				if (cnt_b_q < CNT_W'(MAX_VERTICES)) cnt_b_q <= cnt_b_q + 1'b1;
				else ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_START: begin
				cax_q <= center_a_x;
				cay_q <= center_a_y;
				cbx_q <= center_b_x;
				cby_q <= center_b_y;
				have_q <= 1'b0;
				res_hit_q <= 1'b0;
				res_nx_q <= '0;
				res_ny_q <= '0;
				res_depth_q <= '0;
				res_status_q <= ovf_q ? STATUS_OVF : (short_cnt ? STATUS_FEW : STATUS_OK);
			end
			DP_LATCH0: e0_q <= rd_q;
			DP_EDGE: begin
				ax_q <= ey[32] ? 33'(-ey) : 33'(ey);
				ay_q <= ex[32] ? 33'(-ex) : 33'(ex);
				neg_x_q <= !ey[32] && (ey != '0);
				neg_y_q <= ex[32];
			end
			DP_NORM: begin
				if (m[32:30] != '0) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else if (m[29] == 1'b0) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end
			end
			DP_SQ1: prod_q <= ax_q[29:0] * ax_q[29:0];
			DP_SQ2: begin
				sq_rem_q <= 61'(prod_q) + 61'(sq_y);
				sq_res_q <= '0;
				sq_bit_q <= 61'd1 << 60;
			end
			DP_SQRT: begin
				if ({1'b0, sq_rem_q} >= sq_t) begin
					sq_rem_q <= sq_rem_q - sq_t[60:0];
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			DP_DIVINIT_X: begin
				dr_q <= {2'b0, num_x[44:16]};
				dn_q <= num_x[15:0];
				dq_q <= '0;
			end
			DP_DIVINIT_Y: begin
				qx_q <= q_clamp;
				dr_q <= {2'b0, num_y[44:16]};
				dn_q <= num_y[15:0];
				dq_q <= '0;
			end
			DP_DIV: begin
				dr_q <= dq_bit ? 31'(dt - {1'b0, len}) : dt[30:0];
				dn_q <= dn_q << 1;
				dq_q <= dq_next;
			end
			DP_QY: begin
				nx_q <= neg_x_q ? -$signed(qx_q) : $signed(qx_q);
				ny_q <= neg_y_q ? -$signed(q_clamp) : $signed(q_clamp);
			end
			DP_PMUL: begin
				px_q <= $signed(rd_q[31:0]) * nx_q;
				py_q <= $signed(rd_q[63:32]) * ny_q;
			end
			DP_PACC: begin
				if (!cmd.sel) begin
					if (cmd.first || p < min_a_q) min_a_q <= p;
					if (cmd.first || p > max_a_q) max_a_q <= p;
				end else begin
					if (cmd.first || p < min_b_q) min_b_q <= p;
					if (cmd.first || p > max_b_q) max_b_q <= p;
				end
			end
			DP_AXIS: begin
				if (!have_q || d < best_q) begin
					have_q <= 1'b1;
					best_q <= d;
					bx_q <= nx_q;
					by_q <= ny_q;
				end
			end
			DP_MISS: begin
				res_hit_q <= 1'b0;
				res_nx_q <= '0;
				res_ny_q <= '0;
				res_depth_q <= '0;
				res_status_q <= STATUS_OK;
			end
			DP_FMUL: begin
				fx_q <= dx * bx_q;
				fy_q <= dy * by_q;
			end
			DP_FLIP: begin
				res_hit_q <= 1'b1;
				res_nx_q <= dot[49] ? -bx_q : bx_q;
				res_ny_q <= dot[49] ? -by_q : by_q;
				res_depth_q <= (dep_r[50:46] != '0) ? 32'hFFFF_FFFF : dep_r[45:14];
				res_status_q <= STATUS_OK;
			end
			DP_PUSH: begin
				hit <= res_hit_q;
				normal_x <= res_nx_q;
				normal_y <= res_ny_q;
				depth <= res_depth_q;
				status <= res_status_q;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/cpsat_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences loads, edge normals, projections and
// result hand-off, and owns the output valid flag. Depends on cpsat_pkg.

module cpsat_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [1:0] operation,
	output logic m_tvalid,
	input logic m_tready,
	output cpsat_pkg::cmd_t cmd,
	input cpsat_pkg::stat_t stat
);
	import cpsat_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_RD0 = 5'd1;
	localparam logic [4:0] ST_RD1 = 5'd2;
	localparam logic [4:0] ST_EDGE = 5'd3;
	localparam logic [4:0] ST_NORM = 5'd4;
	localparam logic [4:0] ST_SQ1 = 5'd5;
	localparam logic [4:0] ST_SQ2 = 5'd6;
	localparam logic [4:0] ST_SQRT = 5'd7;
	localparam logic [4:0] ST_DXI = 5'd8;
	localparam logic [4:0] ST_DX = 5'd9;
	localparam logic [4:0] ST_DYI = 5'd10;
	localparam logic [4:0] ST_DY = 5'd11;
	localparam logic [4:0] ST_NQ = 5'd12;
	localparam logic [4:0] ST_PRD = 5'd13;
	localparam logic [4:0] ST_PMUL = 5'd14;
	localparam logic [4:0] ST_PACC = 5'd15;
	localparam logic [4:0] ST_AXIS = 5'd16;
	localparam logic [4:0] ST_FMUL = 5'd17;
	localparam logic [4:0] ST_FLIP = 5'd18;
	localparam logic [4:0] ST_DONE = 5'd19;

	logic [4:0] state_q, state_d;
	logic [IDX_W-1:0] ei_q, ei_d, vi_q, vi_d, ej;
	logic esel_q, esel_d, psel_q, psel_d;
	logic [IT_W-1:0] it_q, it_d;
	logic mvalid_q;
	logic [CNT_W-1:0] ecnt, pcnt, ei_inc, vi_inc;

	assign ecnt = esel_q ? stat.cnt_b : stat.cnt_a;
	assign pcnt = psel_q ? stat.cnt_b : stat.cnt_a;
	assign ei_inc = {1'b0, ei_q} + 1'b1;
	assign vi_inc = {1'b0, vi_q} + 1'b1;
	assign ej = (ei_inc == ecnt) ? '0 : ei_inc[IDX_W-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;

	always_comb begin
		state_d = state_q;
		ei_d = ei_q;
		vi_d = vi_q;
		esel_d = esel_q;
		psel_d = psel_q;
		it_d = it_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (operation)
						OP_LOAD_A: cmd.op = DP_LOAD;
						OP_LOAD_B: begin
							cmd.op = DP_LOAD;
							cmd.sel = 1'b1;
						end
						OP_EVAL: begin
							cmd.op = DP_START;
							ei_d = '0;
							esel_d = 1'b0;
							state_d = stat.err ? ST_DONE : ST_RD0;
						end
						default: ;
					endcase
				end
			end
			ST_RD0: begin
				cmd.rd = 1'b1;
				cmd.sel = esel_q;
				cmd.idx = ei_q;
				state_d = ST_RD1;
			end
			ST_RD1: begin
				cmd.op = DP_LATCH0;
				cmd.rd = 1'b1;
				cmd.sel = esel_q;
				cmd.idx = ej;
				state_d = ST_EDGE;
			end
			ST_EDGE: begin
				cmd.op = DP_EDGE;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				if (stat.zero) begin
					cmd.op = DP_MISS;
					state_d = ST_DONE;
				end else if (stat.m_ok) begin
					state_d = ST_SQ1;
				end else begin
					cmd.op = DP_NORM;
				end
			end
			ST_SQ1: begin
				cmd.op = DP_SQ1;
				state_d = ST_SQ2;
			end
			ST_SQ2: begin
				cmd.op = DP_SQ2;
				it_d = '0;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = DP_SQRT;
				it_d = it_q + 1'b1;
				if (it_q == IT_W'(SQRT_STEPS - 1)) state_d = ST_DXI;
			end
			ST_DXI: begin
				cmd.op = DP_DIVINIT_X;
				it_d = '0;
				state_d = ST_DX;
			end
			ST_DX: begin
				cmd.op = DP_DIV;
				it_d = it_q + 1'b1;
				if (it_q == IT_W'(DIV_STEPS - 1)) state_d = ST_DYI;
			end
			ST_DYI: begin
				cmd.op = DP_DIVINIT_Y;
				it_d = '0;
				state_d = ST_DY;
			end
			ST_DY: begin
				cmd.op = DP_DIV;
				it_d = it_q + 1'b1;
				if (it_q == IT_W'(DIV_STEPS - 1)) state_d = ST_NQ;
			end
			ST_NQ: begin
				cmd.op = DP_QY;
				cmd.rd = 1'b1;
				psel_d = 1'b0;
				vi_d = '0;
				state_d = ST_PMUL;
			end
			ST_PRD: begin
				cmd.rd = 1'b1;
				cmd.sel = psel_q;
				cmd.idx = vi_q;
				state_d = ST_PMUL;
			end
			ST_PMUL: begin
				cmd.op = DP_PMUL;
				state_d = ST_PACC;
			end
			ST_PACC: begin
				cmd.op = DP_PACC;
				cmd.sel = psel_q;
				cmd.first = (vi_q == '0);
				if (vi_inc < pcnt) begin
					vi_d = vi_inc[IDX_W-1:0];
					state_d = ST_PRD;
				end else if (!psel_q) begin
					psel_d = 1'b1;
					vi_d = '0;
					state_d = ST_PRD;
				end else begin
					state_d = ST_AXIS;
				end
			end
			ST_AXIS: begin
				if (stat.gap) begin
					cmd.op = DP_MISS;
					state_d = ST_DONE;
				end else begin
					cmd.op = DP_AXIS;
					if (ei_inc < ecnt) begin
						ei_d = ei_inc[IDX_W-1:0];
						state_d = ST_RD0;
					end else if (!esel_q) begin
						esel_d = 1'b1;
						ei_d = '0;
						state_d = ST_RD0;
					end else begin
						state_d = ST_FMUL;
					end
				end
			end
			ST_FMUL: begin
				cmd.op = DP_FMUL;
				state_d = ST_FLIP;
			end
			ST_FLIP: begin
				cmd.op = DP_FLIP;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!mvalid_q || m_tready) begin
					cmd.op = DP_PUSH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ei_q <= '0;
			vi_q <= '0;
			esel_q <= 1'b0;
			psel_q <= 1'b0;
			it_q <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ei_q <= ei_d;
			vi_q <= vi_d;
			esel_q <= esel_d;
			psel_q <= psel_d;
			it_q <= it_d;
			if (cmd.op == DP_PUSH) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_sqrt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT |-> it_q <= IT_W'(SQRT_STEPS - 1))
		else $error("root iteration count out of range");
	a_edge_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD0 |-> {1'b0, ei_q} < ecnt)
		else $error("edge index beyond vertex count");
	a_eval_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && operation == OP_EVAL && !stat.err |=> state_q == ST_RD0)
		else $error("evaluate did not start the edge walk");
	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && (!mvalid_q || m_tready) |=> mvalid_q && state_q == ST_IDLE)
		else $error("result transfer not issued");
`endif

endmodule

>>> rtl/convex_polygon_sat_test_unit.sv
`timescale 1ns / 1ps
// Top level of the convex polygon separating-axis test unit.
// Instantiates cpsat_ctrl and cpsat_dp; depends on cpsat_pkg.
//
// Input stream: s_tuser carries the operation (load into A, load into B,
// evaluate); s_tdata carries the vertex and the two centers. A load transfer
// returns nothing. An evaluate transfer returns one result transfer on the m
// stream with hit, normal, depth and status.
// Evaluate walks each of the nA + nB edges: one-bit normalizing shifts, then
// the edge normal (one bit per cycle in the square root and the two
// divisions), the projections of every vertex of both polygons and the axis
// decision; then it finishes the result. An error status (too few vertices
// or overflow) returns without the walk, and a separating axis ends the walk
// early. One item is processed at a time.
// The result register holds the result while the receiver stalls; the block
// keeps taking loads meanwhile and only waits when a new result is ready.
// Reset empties both vertex stores, clears the overflow flag and drops any
// pending result. Evaluate empties both stores when it finishes.

module convex_polygon_sat_test_unit (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// vertex_x, vertex_y, center_a_x, center_a_y, center_b_x, center_b_y
	input logic [191:0] s_tdata,
	// operation
	input logic [1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// hit, normal_x, normal_y, depth, status, zero fill
	output logic [71:0] m_tdata
);
	import cpsat_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic hit;
	logic signed [15:0] normal_x, normal_y;
	logic [31:0] depth;
	logic [1:0] status;

	cpsat_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.operation(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd(cmd),
		.stat(stat)
	);

	cpsat_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.vertex_x(s_tdata[31:0]),
		.vertex_y(s_tdata[63:32]),
		.center_a_x(s_tdata[95:64]),
		.center_a_y(s_tdata[127:96]),
		.center_b_x(s_tdata[159:128]),
		.center_b_y(s_tdata[191:160]),
		.hit(hit),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.depth(depth),
		.status(status)
	);

	assign m_tdata = {5'd0, status, depth, normal_y, normal_x, hit};

endmodule
